// ===== hw/rtl/mprf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprf_pkg: shared types and constants of the pattern rectangle fill engine
// Opcodes, register indexes, write modes, pattern table and pixel helpers.
// ----------------------------------------------------------------------------
package mprf_pkg;

  // Command opcodes
  localparam logic [1:0] OP_FILL = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_INTERIOR_KIND = 3'd0;
  localparam logic [2:0] CFG_STYLE_INDEX   = 3'd1;
  localparam logic [2:0] CFG_WRITE_MODE    = 3'd2;
  localparam logic [2:0] CFG_CLIP_LEFT     = 3'd3;
  localparam logic [2:0] CFG_CLIP_TOP      = 3'd4;
  localparam logic [2:0] CFG_CLIP_RIGHT    = 3'd5;
  localparam logic [2:0] CFG_CLIP_BOTTOM   = 3'd6;

  // Interior kinds
  localparam logic [2:0] KIND_HOLLOW = 3'd0;
  localparam logic [2:0] KIND_SOLID  = 3'd1;
  localparam logic [2:0] KIND_USER   = 3'd4;

  // Write modes; every other code is replace
  localparam logic [2:0] MODE_REPLACE = 3'd1;
  localparam logic [2:0] MODE_OR      = 3'd2;
  localparam logic [2:0] MODE_XOR     = 3'd3;
  localparam logic [2:0] MODE_ERASE   = 3'd4;

  // Style used when the style index is outside 1..8
  localparam logic [3:0] STYLE_FALLBACK = 4'd2;
  localparam logic [3:0] STYLE_LAST     = 4'd8;

  localparam logic [15:0] PAT_ALL_ONES = 16'hffff;

  // Configuration register set
  typedef struct packed {
    logic [2:0] interior_kind;
    logic [3:0] style_index;
    logic [2:0] write_mode;
    logic [9:0] clip_left;
    logic [8:0] clip_top;
    logic [9:0] clip_right;
    logic [8:0] clip_bottom;
  } mprf_cfg_t;

  // Fill walker status toward the command sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mprf_wk_stat_t;

  // Built-in patterns: even row word, odd row word
  function automatic logic [15:0] builtin_word(input logic [2:0] idx,
                                               input logic       row_odd);
    logic [15:0] even_w;
    logic [15:0] odd_w;
    case (idx)
      3'd0:    begin even_w = 16'hffff; odd_w = 16'hffff; end
      3'd1:    begin even_w = 16'haaaa; odd_w = 16'h5555; end
      3'd2:    begin even_w = 16'h8888; odd_w = 16'h2222; end
      3'd3:    begin even_w = 16'hcccc; odd_w = 16'h3333; end
      3'd4:    begin even_w = 16'hf0f0; odd_w = 16'h0f0f; end
      3'd5:    begin even_w = 16'hff00; odd_w = 16'h0000; end
      3'd6:    begin even_w = 16'hffff; odd_w = 16'h0000; end
      default: begin even_w = 16'h8080; odd_w = 16'h0808; end
    endcase
    return row_odd ? odd_w : even_w;
  endfunction

  // Pattern word of one row for the selected interior
  function automatic logic [15:0] pattern_word(input logic [2:0]  kind,
                                               input logic [3:0]  style,
                                               input logic        row_odd,
                                               input logic [15:0] user_word);
    logic [3:0] s;
    logic [2:0] idx;
    s = style;
    if (s == 4'd0 || s > STYLE_LAST) begin
      s = STYLE_FALLBACK;
    end
    idx = 3'(s - 4'd1);
    if (kind == KIND_SOLID) begin
      return PAT_ALL_ONES;
    end else if (kind == KIND_USER) begin
      return user_word;
    end
    return builtin_word(idx, row_odd);
  endfunction

  // Rewrite one byte under the span mask
  function automatic logic [7:0] apply_mode(input logic [2:0] mode,
                                            input logic       ink,
                                            input logic [7:0] cur,
                                            input logic [7:0] pat,
                                            input logic [7:0] span);
    logic [7:0] want;
    want = ink ? pat : ~pat;
    case (mode)
      MODE_OR:    return ink ? (cur | (pat & span)) : cur;
      MODE_XOR:   return ink ? (cur ^ (pat & span)) : cur;
      MODE_ERASE: return cur & ~span;
      default:    return (cur & ~span) | (want & span);
    endcase
  endfunction

endpackage

// ===== hw/rtl/mprf_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprf_store: packed frame store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mprf_store #(
  parameter int DEPTH = 32000,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/mprf_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprf_walker: rectangle fill walker
// Orders and clips the corners, then walks the covered bytes row by row with
// one read-modify-write per byte, each byte written back in the cycle after it is read.
// ----------------------------------------------------------------------------
module mprf_walker
  import mprf_pkg::*;
#(
  parameter int BYTES_PER_ROW = 80,
  parameter int ROWS          = 400,
  localparam int AW = $clog2(BYTES_PER_ROW * ROWS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mprf_cfg_t          cfg,
  input  logic               start,
  input  logic signed [15:0] corner_ax,
  input  logic signed [15:0] corner_ay,
  input  logic signed [15:0] corner_bx,
  input  logic signed [15:0] corner_by,
  input  logic               ink,
  output logic [3:0]         upat_row,
  input  logic [15:0]        upat_word,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  logic [7:0]         rd_data,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data,
  output mprf_wk_stat_t      stat
);

  localparam int BW = $clog2(BYTES_PER_ROW);
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic signed [16:0] XMAX = 17'(BYTES_PER_ROW * 8 - 1);
  localparam logic signed [16:0] YMAX = 17'(ROWS - 1);
  localparam logic [AW-1:0] ROW_STEP = AW'(BYTES_PER_ROW);

  typedef enum logic [5:0] {
    W_IDLE  = 6'b000001,
    W_CLIP  = 6'b000010,
    W_PREP  = 6'b000100,
    W_ROW   = 6'b001000,
    W_RUN   = 6'b010000,
    W_DRAIN = 6'b100000
  } wk_state_t;

  wk_state_t state_r, state_nxt;

  logic signed [15:0] ax_r, ay_r, bx_r, by_r;
  logic               ink_r;
  logic signed [16:0] xl_r, xr_r, yt_r, yb_r;
  logic [BW-1:0]      sb_r, eb_r, b_r;
  logic [7:0]         lmask_r, rmask_r;
  logic [RW-1:0]      y_r, ybot_r;
  logic [AW-1:0]      base_r, addr_r;
  logic [15:0]        pw_r;
  logic               p1_valid_r;
  logic [AW-1:0]      p1_addr_r;
  logic [7:0]         p1_span_r, p1_pat_r;

  // Clip terms
  logic signed [16:0] xlo, xhi, ylo, yhi;
  logic signed [16:0] cl, cr, ct, cb;
  logic signed [16:0] xl_c, xr_c, xr_cc, yt_c, yb_c, yb_cc;
  logic               empty;
  logic [RW+3:0]      y_pad;
  logic [7:0]         span, pat;
  logic               row_last, col_last;

  // Order the corners and clip to the clip rectangle and the store
  always_comb begin
    xlo = (ax_r < bx_r) ? 17'(ax_r) : 17'(bx_r);
    xhi = (ax_r < bx_r) ? 17'(bx_r) : 17'(ax_r);
    ylo = (ay_r < by_r) ? 17'(ay_r) : 17'(by_r);
    yhi = (ay_r < by_r) ? 17'(by_r) : 17'(ay_r);
    cl  = $signed({7'd0, cfg.clip_left});
    cr  = $signed({7'd0, cfg.clip_right});
    ct  = $signed({8'd0, cfg.clip_top});
    cb  = $signed({8'd0, cfg.clip_bottom});
    xl_c  = (xlo < cl) ? cl : xlo;
    xr_c  = (xhi > cr) ? cr : xhi;
    xr_cc = (xr_c > XMAX) ? XMAX : xr_c;
    yt_c  = (ylo < ct) ? ct : ylo;
    yb_c  = (yhi > cb) ? cb : yhi;
    yb_cc = (yb_c > YMAX) ? YMAX : yb_c;
  end

  assign empty = (xl_r > xr_r) || (yt_r > yb_r) || (cfg.interior_kind == KIND_HOLLOW);

  // Current byte position
  assign y_pad    = {4'd0, y_r};
  assign upat_row = y_pad[3:0];
  assign col_last = (b_r == eb_r);
  assign row_last = (y_r == ybot_r);
  assign span = ((b_r == sb_r) ? lmask_r : 8'hff) & (col_last ? rmask_r : 8'hff);
  assign pat  = b_r[0] ? pw_r[7:0] : pw_r[15:8];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      W_IDLE:  if (start) state_nxt = W_CLIP;
      W_CLIP:  state_nxt = W_PREP;
      W_PREP:  state_nxt = empty ? W_IDLE : W_ROW;
      W_ROW:   state_nxt = W_RUN;
      W_RUN: begin
        if (col_last) state_nxt = row_last ? W_DRAIN : W_ROW;
      end
      W_DRAIN: state_nxt = W_IDLE;
      default: state_nxt = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= W_IDLE;
      p1_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      p1_valid_r <= (state_r == W_RUN);
    end
  end

  // Capture, clip, set up and walk
  always_ff @(posedge clk) begin
    if (state_r == W_IDLE && start) begin
      ax_r  <= corner_ax;
      ay_r  <= corner_ay;
      bx_r  <= corner_bx;
      by_r  <= corner_by;
      ink_r <= ink;
    end
    if (state_r == W_CLIP) begin
      xl_r <= xl_c;
      xr_r <= xr_cc;
      yt_r <= yt_c;
      yb_r <= yb_cc;
    end
    if (state_r == W_PREP) begin
      sb_r    <= xl_r[BW+2:3];
      eb_r    <= xr_r[BW+2:3];
      lmask_r <= 8'hff >> xl_r[2:0];
      rmask_r <= 8'hff << (3'd7 - xr_r[2:0]);
      y_r     <= yt_r[RW-1:0];
      ybot_r  <= yb_r[RW-1:0];
      base_r  <= AW'(yt_r[RW-1:0] * BYTES_PER_ROW);
    end
    if (state_r == W_ROW) begin
      pw_r   <= pattern_word(cfg.interior_kind, cfg.style_index, y_r[0], upat_word);
      b_r    <= sb_r;
      addr_r <= base_r + AW'(sb_r);
    end
    if (state_r == W_RUN) begin
      b_r       <= b_r + 1'b1;
      addr_r    <= addr_r + 1'b1;
      p1_addr_r <= addr_r;
      p1_span_r <= span;
      p1_pat_r  <= pat;
      if (col_last && !row_last) begin
        y_r    <= y_r + 1'b1;
        base_r <= base_r + ROW_STEP;
      end
    end
  end

  // Memory side: read this byte, write back the one read last cycle
  assign rd_en   = (state_r == W_RUN);
  assign rd_addr = addr_r;
  assign wr_en   = p1_valid_r;
  assign wr_addr = p1_addr_r;
  assign wr_data = apply_mode(cfg.write_mode, ink_r, rd_data, p1_pat_r, p1_span_r);

  assign stat.busy = (state_r != W_IDLE);
  assign stat.done = (state_r == W_DRAIN) || (state_r == W_PREP && empty);

endmodule

// ===== hw/rtl/mono_pattern_rect_fill_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_pattern_rect_fill_core: 1 bpp pattern rectangle fill engine
// Owns the frame store and user pattern, sequences fill, load and readback.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | sink      | in_valid / in_stall | opcode, corners, ink, pattern, address
//  out_    | source    | out_valid/out_stall | read_data
//  cfg_    | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  Load and unknown opcodes complete in the idle state; a read waits in S_READ for a
//  free output register. A fill stalls the input through the walker's single
//  read-modify-write pass; an empty or hollow fill writes nothing.
//  After reset a clearing pass zeroes the store, one byte a cycle, with in_stall
//  high; configuration is taken always.
//  A stalled result holds in the output register while the next item enters.
// ----------------------------------------------------------------------------
module mono_pattern_rect_fill_core
  import mprf_pkg::*;
#(
  parameter int BYTES_PER_ROW = 80,
  parameter int ROWS          = 400
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic signed [15:0] in_corner_ax,
  input  logic signed [15:0] in_corner_ay,
  input  logic signed [15:0] in_corner_bx,
  input  logic signed [15:0] in_corner_by,
  input  logic               in_ink,
  input  logic [3:0]         in_pattern_row,
  input  logic [15:0]        in_pattern_bits,
  input  logic [14:0]        in_read_address,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_read_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [9:0]         cfg_data
);

  localparam int STORE_BYTES = BYTES_PER_ROW * ROWS;
  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(STORE_BYTES - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_FILL  = 4'b0100,
    S_READ  = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  mprf_cfg_t     cfg_r;
  logic [15:0]   upat_r [16];
  logic [AW-1:0] clr_addr_r;
  logic          rd_hit_r;
  logic          out_valid_r;
  logic [7:0]    out_data_r;

  logic          in_accept, out_free;
  logic          is_fill, is_load, is_read;
  logic [31:0]   raddr_ext;
  logic          raddr_ok;

  logic          wk_start;
  logic [3:0]    wk_upat_row;
  logic          wk_rd_en, wk_wr_en;
  logic [AW-1:0] wk_rd_addr, wk_wr_addr;
  logic [7:0]    wk_wr_data;
  mprf_wk_stat_t wk_stat;

  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  logic [7:0]    mem_wr_data, mem_rd_data;

  // Decode the incoming transaction
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign is_fill   = (in_opcode == OP_FILL);
  assign is_load   = (in_opcode == OP_LOAD);
  assign is_read   = (in_opcode == OP_READ);
  assign raddr_ext = {17'd0, in_read_address};
  assign raddr_ok  = (raddr_ext < 32'(STORE_BYTES));
  assign out_free  = !out_valid_r || !out_stall;
  assign wk_start  = in_accept && is_fill;

  // Command sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_addr_r == CLR_LAST) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_accept && is_fill) state_nxt = S_FILL;
        if (in_accept && is_read) state_nxt = S_READ;
      end
      S_FILL:  if (wk_stat.done) state_nxt = S_IDLE;
      S_READ:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interior_kind <= KIND_SOLID;
      cfg_r.style_index   <= 4'd1;
      cfg_r.write_mode    <= MODE_REPLACE;
      cfg_r.clip_left     <= 10'd0;
      cfg_r.clip_top      <= 9'd0;
      cfg_r.clip_right    <= 10'd639;
      cfg_r.clip_bottom   <= 9'd399;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INTERIOR_KIND: cfg_r.interior_kind <= cfg_data[2:0];
        CFG_STYLE_INDEX:   cfg_r.style_index   <= cfg_data[3:0];
        CFG_WRITE_MODE:    cfg_r.write_mode    <= cfg_data[2:0];
        CFG_CLIP_LEFT:     cfg_r.clip_left     <= cfg_data;
        CFG_CLIP_TOP:      cfg_r.clip_top      <= cfg_data[8:0];
        CFG_CLIP_RIGHT:    cfg_r.clip_right    <= cfg_data;
        CFG_CLIP_BOTTOM:   cfg_r.clip_bottom   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // User pattern rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) upat_r[i] <= 16'd0;
    end else if (in_accept && is_load) begin
      upat_r[in_pattern_row] <= in_pattern_bits;
    end
  end

  // Remember whether the readback address lies in the store
  always_ff @(posedge clk) begin
    if (in_accept && is_read) rd_hit_r <= raddr_ok;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_READ && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ && out_free) out_data_r <= rd_hit_r ? mem_rd_data : 8'd0;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  // Frame store port steering
  assign mem_wr_en   = (state_r == S_CLEAR) || wk_wr_en;
  assign mem_wr_addr = (state_r == S_CLEAR) ? clr_addr_r : wk_wr_addr;
  assign mem_wr_data = (state_r == S_CLEAR) ? 8'd0 : wk_wr_data;
  assign mem_rd_en   = wk_rd_en || (in_accept && is_read);
  assign mem_rd_addr = wk_rd_en ? wk_rd_addr : raddr_ext[AW-1:0];

  mprf_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  mprf_walker #(
    .BYTES_PER_ROW (BYTES_PER_ROW),
    .ROWS          (ROWS)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (wk_start),
    .corner_ax (in_corner_ax),
    .corner_ay (in_corner_ay),
    .corner_bx (in_corner_bx),
    .corner_by (in_corner_by),
    .ink       (in_ink),
    .upat_row  (wk_upat_row),
    .upat_word (upat_r[wk_upat_row]),
    .rd_en     (wk_rd_en),
    .rd_addr   (wk_rd_addr),
    .rd_data   (mem_rd_data),
    .wr_en     (wk_wr_en),
    .wr_addr   (wk_wr_addr),
    .wr_data   (wk_wr_data),
    .stat      (wk_stat)
  );

  // Walker writes only while a fill is in flight
  a_wk_write_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    wk_wr_en |-> (state_r == S_FILL))
    else $error("walker write outside a fill");

  // Walker is at rest whenever the sequencer can take a transaction
  a_wk_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wk_stat.busy)
    else $error("walker busy while sequencer idle");

  // No transaction enters during the clearing pass
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("input taken during clearing pass");

  // A readback with a free output slot presents its result next cycle
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && out_free) |=> out_valid)
    else $error("readback result not presented");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 1 bpp pattern rectangle fill engine
// Drives fill, pattern load and readback transactions through phases of
// register settings, mirrors the frame store and user pattern in a local
// model, and compares every readback byte in order with the predicted one.
// ----------------------------------------------------------------------------
module tb;
  import mprf_pkg::*;

  localparam int BYTES_PER_ROW = 80;
  localparam int ROWS          = 400;
  localparam int STORE_BYTES   = BYTES_PER_ROW * ROWS;
  localparam int MAX_X         = BYTES_PER_ROW * 8 - 1;
  localparam int MAX_Y         = ROWS - 1;

  // Opcode the block ignores
  localparam logic [1:0] OP_NONE = 2'd3;

  // Interior kinds and write modes without a package name
  localparam logic [2:0] KIND_PATTERN = 3'd2;
  localparam logic [2:0] KIND_HATCH   = 3'd3;
  localparam logic [2:0] KIND_RSVD5   = 3'd5;
  localparam logic [2:0] KIND_RSVD6   = 3'd6;
  localparam logic [2:0] KIND_RSVD7   = 3'd7;
  localparam logic [2:0] MODE_REPL_A  = 3'd0;
  localparam logic [2:0] MODE_REPL_B  = 3'd5;
  localparam logic [2:0] MODE_REPL_C  = 3'd6;
  localparam logic [2:0] MODE_REPL_D  = 3'd7;

  localparam int NUM_FIXED       = 11;
  localparam int NUM_PHASES      = 14;
  localparam int ITEMS_PER_PHASE = 64;
  localparam int NUM_DIRECTED    = 25;
  localparam int HOLD_CYCLES     = 400;
  localparam int IDLE_PAUSE      = 16;
  localparam int END_PAUSE       = 32;
  // The limit leaves room for the clearing pass, two full-screen fills and the
  // large random fills, even with stalls.
  localparam int CYCLE_LIMIT     = 5_000_000;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic               ink;
    logic [3:0]         prow;
    logic [15:0]        pbits;
    logic [14:0]        raddr;
    logic               has_lit;
    logic [7:0]         lit;
  } engine_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] style;
    logic [2:0] mode;
    logic [9:0] cl;
    logic [8:0] ct;
    logic [9:0] cr;
    logic [8:0] cb;
    logic       tight;
  } setting_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_opcode;
  logic signed [15:0] in_corner_ax;
  logic signed [15:0] in_corner_ay;
  logic signed [15:0] in_corner_bx;
  logic signed [15:0] in_corner_by;
  logic               in_ink;
  logic [3:0]         in_pattern_row;
  logic [15:0]        in_pattern_bits;
  logic [14:0]        in_read_address;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         out_read_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [9:0]         cfg_data;

  // Local copy of the engine state
  logic [7:0]  frame_model [0:STORE_BYTES-1];
  logic [15:0] user_rows [0:15];
  mprf_cfg_t   regs;
  logic [7:0]  readback_q [$];

  int  mismatches;
  int  cycles;
  bit  no_idle;
  bit  hold_go;
  int  last_x, last_y, last_w, last_h;

  // Directed table: reset contents, store extremes, ordering, beyond-store
  // clipping, pattern loads and the ignored opcode.
  engine_cmd_t directed [0:NUM_DIRECTED-1] = '{
    '{OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'h0000, 15'd0, 1'b1, 8'h00},
    '{OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'h0000, 15'd31999, 1'b1, 8'h00},
    '{OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'h0000, 15'd32767, 1'b1, 8'h00},
    '{OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'h0000, 15'd32000, 1'b1, 8'h00},
    '{OP_FILL, 16'sd0, 16'sd0, 16'sd7, 16'sd0, 1'b1, 4'd0, 16'h0000, 15'd0, 1'b0, 8'h00},
    '{OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'h0000, 15'd0, 1'b1, 8'hff},
    '{OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'h0000, 15'd1, 1'b1, 8'h00},
    '{OP_FILL, 16'sd13, 16'sd3, 16'sd3, 16'sd1, 1'b1, 4'd0, 16'h0000, 15'd0, 1'b0, 8'h00},
    '{OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'h0000, 15'd80, 1'b0, 8'h00},
    '{OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'h0000, 15'd81, 1'b0, 8'h00},
    '{OP_FILL, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0, 4'd0, 16'h0000, 15'd0,
      1'b0, 8'h00},
    '{OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'h0000, 15'd0, 1'b1, 8'h00},
    '{OP_FILL, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b1, 4'd0, 16'h0000, 15'd0,
      1'b0, 8'h00},
    '{OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'h0000, 15'd31999, 1'b1, 8'hff},
    '{OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'h0000, 15'd15999, 1'b1, 8'hff},
    '{OP_FILL, 16'sd700, 16'sd10, 16'sd900, 16'sd20, 1'b0, 4'd0, 16'h0000, 15'd0, 1'b0, 8'h00},
    '{OP_FILL, -16'sd5, -16'sd5, -16'sd1, -16'sd1, 1'b0, 4'd0, 16'h0000, 15'd0, 1'b0, 8'h00},
    '{OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'h0000, 15'd0, 1'b1, 8'hff},
    '{OP_LOAD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'hffff, 15'd0, 1'b0, 8'h00},
    '{OP_LOAD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd15, 16'h0000, 15'd0, 1'b0, 8'h00},
    '{OP_LOAD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd7, 16'ha5c3, 15'd0, 1'b0, 8'h00},
    '{OP_NONE, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 1'b1, 4'd15, 16'hffff, 15'h7fff,
      1'b0, 8'h00},
    '{OP_FILL, 16'sd639, 16'sd399, 16'sd639, 16'sd399, 1'b0, 4'd0, 16'h0000, 15'd0,
      1'b0, 8'h00},
    '{OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'h0000, 15'd31999, 1'b1, 8'hfe},
    '{OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 4'd0, 16'h0000, 15'd32767, 1'b1, 8'h00}
  };

  // Fixed register settings: every kind, mode and style class, clip extremes
  setting_t plan [0:NUM_FIXED-1] = '{
    '{KIND_SOLID,   4'd1,  MODE_REPLACE, 10'd0,   9'd0,   10'd639,  9'd399, 1'b0},
    '{KIND_PATTERN, 4'd0,  MODE_OR,      10'd0,   9'd0,   10'd639,  9'd399, 1'b0},
    '{KIND_HATCH,   4'd15, MODE_XOR,     10'd8,   9'd16,  10'd300,  9'd200, 1'b0},
    '{KIND_USER,    4'd8,  MODE_ERASE,   10'd0,   9'd0,   10'd639,  9'd399, 1'b0},
    '{KIND_USER,    4'd3,  MODE_REPL_A,  10'd100, 9'd50,  10'd400,  9'd250, 1'b0},
    '{KIND_HOLLOW,  4'd5,  MODE_REPLACE, 10'd0,   9'd0,   10'd639,  9'd399, 1'b0},
    '{KIND_RSVD5,   4'd9,  MODE_REPL_B,  10'd600, 9'd380, 10'd639,  9'd399, 1'b1},
    '{KIND_RSVD6,   4'd6,  MODE_XOR,     10'd300, 9'd0,   10'd200,  9'd399, 1'b1},
    '{KIND_RSVD7,   4'd7,  MODE_OR,      10'd0,   9'd300, 10'd639,  9'd100, 1'b1},
    '{KIND_PATTERN, 4'd4,  MODE_REPL_C,  10'd639, 9'd399, 10'd1023, 9'd511, 1'b1},
    '{KIND_USER,    4'd2,  MODE_REPL_D,  10'd0,   9'd0,   10'd1023, 9'd511, 1'b0}
  };

  mono_pattern_rect_fill_core #(
    .BYTES_PER_ROW(BYTES_PER_ROW),
    .ROWS         (ROWS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_corner_ax   (in_corner_ax),
    .in_corner_ay   (in_corner_ay),
    .in_corner_bx   (in_corner_bx),
    .in_corner_by   (in_corner_by),
    .in_ink         (in_ink),
    .in_pattern_row (in_pattern_row),
    .in_pattern_bits(in_pattern_bits),
    .in_read_address(in_read_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Row word of a built-in pattern
  function automatic logic [15:0] builtin_row(input logic [3:0] style, input logic odd);
    logic [15:0] even_w;
    logic [15:0] odd_w;
    case (style)
      4'd1:    begin even_w = 16'hffff; odd_w = 16'hffff; end
      4'd3:    begin even_w = 16'h8888; odd_w = 16'h2222; end
      4'd4:    begin even_w = 16'hcccc; odd_w = 16'h3333; end
      4'd5:    begin even_w = 16'hf0f0; odd_w = 16'h0f0f; end
      4'd6:    begin even_w = 16'hff00; odd_w = 16'h0000; end
      4'd7:    begin even_w = 16'hffff; odd_w = 16'h0000; end
      4'd8:    begin even_w = 16'h8080; odd_w = 16'h0808; end
      default: begin even_w = 16'haaaa; odd_w = 16'h5555; end
    endcase
    return odd ? odd_w : even_w;
  endfunction

  // Pattern word for absolute row y under the current interior
  function automatic logic [15:0] row_pattern(input int y);
    if (regs.interior_kind == KIND_SOLID) begin
      return 16'hffff;
    end
    if (regs.interior_kind == KIND_USER) begin
      return user_rows[y & 15];
    end
    return builtin_row(regs.style_index, y[0]);
  endfunction

  // Order, clip and paint one rectangle into the model store
  function automatic void paint_rect(input engine_cmd_t c);
    int x0, x1, y0, y1, sb, eb, addr;
    logic [15:0] pw;
    logic [7:0]  lmask, rmask, span, pat, cur, want;
    x0 = ($signed(c.ax) < $signed(c.bx)) ? $signed(c.ax) : $signed(c.bx);
    x1 = ($signed(c.ax) < $signed(c.bx)) ? $signed(c.bx) : $signed(c.ax);
    y0 = ($signed(c.ay) < $signed(c.by)) ? $signed(c.ay) : $signed(c.by);
    y1 = ($signed(c.ay) < $signed(c.by)) ? $signed(c.by) : $signed(c.ay);
    if (x0 < int'(regs.clip_left)) x0 = int'(regs.clip_left);
    if (y0 < int'(regs.clip_top)) y0 = int'(regs.clip_top);
    if (x1 > int'(regs.clip_right)) x1 = int'(regs.clip_right);
    if (y1 > int'(regs.clip_bottom)) y1 = int'(regs.clip_bottom);
    if (x1 > MAX_X) x1 = MAX_X;
    if (y1 > MAX_Y) y1 = MAX_Y;
    if (x0 > x1 || y0 > y1 || regs.interior_kind == KIND_HOLLOW) begin
      return;
    end
    sb = x0 / 8;
    eb = x1 / 8;
    lmask = 8'hff >> (x0 & 7);
    rmask = 8'hff << (7 - (x1 & 7));
    for (int y = y0; y <= y1; y++) begin
      pw = row_pattern(y);
      for (int b = sb; b <= eb; b++) begin
        span = 8'hff;
        if (b == sb) span = span & lmask;
        if (b == eb) span = span & rmask;
        pat  = (b & 1) ? pw[7:0] : pw[15:8];
        addr = y * BYTES_PER_ROW + b;
        cur  = frame_model[addr];
        case (regs.write_mode)
          MODE_OR: begin
            if (c.ink) cur = cur | (pat & span);
          end
          MODE_XOR: begin
            if (c.ink) cur = cur ^ (pat & span);
          end
          MODE_ERASE: begin
            cur = cur & ~span;
          end
          default: begin
            want = c.ink ? pat : ~pat;
            cur  = (cur & ~span) | (want & span);
          end
        endcase
        frame_model[addr] = cur;
      end
    end
  endfunction

  // Advance the model by one accepted transaction
  function automatic void apply_cmd(input engine_cmd_t c);
    case (c.op)
      OP_FILL: paint_rect(c);
      OP_LOAD: user_rows[c.prow] = c.pbits;
      OP_READ: begin
        if (int'(c.raddr) < STORE_BYTES) begin
          readback_q.push_back(frame_model[c.raddr]);
        end else begin
          readback_q.push_back(8'h00);
        end
      end
      default: ;
    endcase
  endfunction

  // Random transaction; most fills are small so that runs stay short
  function automatic engine_cmd_t random_cmd(input bit tight);
    engine_cmd_t c;
    int pick, x, y, w, h;
    c.ax      = 16'($urandom);
    c.ay      = 16'($urandom);
    c.bx      = 16'($urandom);
    c.by      = 16'($urandom);
    c.ink     = 1'($urandom);
    c.prow    = 4'($urandom);
    c.pbits   = 16'($urandom);
    c.raddr   = 15'($urandom);
    c.has_lit = 1'b0;
    c.lit     = 8'h00;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c.op  = OP_FILL;
      c.ink = ($urandom_range(0, 99) < 70);
      if (tight && $urandom_range(0, 99) < 30) begin
        // keep full-range corners; target reads at the clip window
        last_x = int'(regs.clip_left);
        last_y = int'(regs.clip_top);
        last_w = (regs.clip_right > regs.clip_left) ?
                 int'(regs.clip_right) - int'(regs.clip_left) : 0;
        last_h = (regs.clip_bottom > regs.clip_top) ?
                 int'(regs.clip_bottom) - int'(regs.clip_top) : 0;
        return c;
      end
      if (!tight && $urandom_range(0, 99) < 3) begin
        x = $urandom_range(0, 739);
        x = x - 50;
        y = $urandom_range(0, 499);
        y = y - 50;
        w = $urandom_range(0, 700);
        h = $urandom_range(0, 500);
      end else begin
        x = $urandom_range(0, 140);
        y = $urandom_range(0, 30);
        if (tight) begin
          x = x + int'(regs.clip_left) - 20;
          y = y + int'(regs.clip_top) - 10;
        end else begin
          x = $urandom_range(0, 679);
          x = x - 20;
          y = $urandom_range(0, 419);
          y = y - 10;
        end
        w = $urandom_range(0, 40);
        h = $urandom_range(0, 10);
      end
      if ($urandom_range(0, 1)) begin
        c.ax = 16'(x);
        c.bx = 16'(x + w);
      end else begin
        c.ax = 16'(x + w);
        c.bx = 16'(x);
      end
      if ($urandom_range(0, 1)) begin
        c.ay = 16'(y);
        c.by = 16'(y + h);
      end else begin
        c.ay = 16'(y + h);
        c.by = 16'(y);
      end
      last_x = x;
      last_y = y;
      last_w = w;
      last_h = h;
    end else if (pick < 60) begin
      c.op = OP_LOAD;
    end else if (pick < 95) begin
      c.op = OP_READ;
      pick = $urandom_range(0, 99);
      x = $urandom_range(0, last_w);
      x = x + last_x;
      y = $urandom_range(0, last_h);
      y = y + last_y;
      if (pick < 60 && x >= 0 && x <= MAX_X && y >= 0 && y <= MAX_Y) begin
        c.raddr = 15'(y * BYTES_PER_ROW + x / 8);
      end else if (pick < 90) begin
        c.raddr = 15'($urandom_range(0, STORE_BYTES - 1));
      end else begin
        c.raddr = 15'($urandom_range(0, 32767));
      end
    end else begin
      c.op = OP_NONE;
    end
    return c;
  endfunction

  // Offer one transaction and update the model when it is taken
  task automatic send_cmd(input engine_cmd_t c);
    while (!no_idle && $urandom_range(0, 99) < 15) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_opcode       <= c.op;
    in_corner_ax    <= c.ax;
    in_corner_ay    <= c.ay;
    in_corner_bx    <= c.bx;
    in_corner_by    <= c.by;
    in_ink          <= c.ink;
    in_pattern_row  <= c.prow;
    in_pattern_bits <= c.pbits;
    in_read_address <= c.raddr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c.has_lit) begin
      readback_q.push_back(c.lit);
    end else begin
      apply_cmd(c);
    end
  endtask

  // Write one configuration register and mirror it
  task automatic write_reg(input logic [2:0] idx, input logic [9:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_INTERIOR_KIND: regs.interior_kind = data[2:0];
      CFG_STYLE_INDEX:   regs.style_index   = data[3:0];
      CFG_WRITE_MODE:    regs.write_mode    = data[2:0];
      CFG_CLIP_LEFT:     regs.clip_left     = data[9:0];
      CFG_CLIP_TOP:      regs.clip_top      = data[8:0];
      CFG_CLIP_RIGHT:    regs.clip_right    = data[9:0];
      CFG_CLIP_BOTTOM:   regs.clip_bottom   = data[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input setting_t s);
    write_reg(CFG_INTERIOR_KIND, 10'(s.kind));
    write_reg(CFG_STYLE_INDEX,   10'(s.style));
    write_reg(CFG_WRITE_MODE,    10'(s.mode));
    write_reg(CFG_CLIP_LEFT,     s.cl);
    write_reg(CFG_CLIP_TOP,      10'(s.ct));
    write_reg(CFG_CLIP_RIGHT,    s.cr);
    write_reg(CFG_CLIP_BOTTOM,   10'(s.cb));
  endtask

  // Drop valid, wait for every readback, then let a trailing fill settle
  task automatic drain(input int pause);
    @(negedge clk);
    in_valid <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk);
    repeat (pause) @(posedge clk);
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < 15);
      end
    end
  end

  // Compare each readback transaction with the oldest predicted byte
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (readback_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("readback with nothing pending: got %02h", out_read_data);
        end
      end else begin
        if (out_read_data !== readback_q[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("readback mismatch: expected %02h got %02h",
                     readback_q[0], out_read_data);
          end
        end
        void'(readback_q.pop_front());
      end
    end
  end

  // Timeout
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("mono_pattern_rect_fill_core: mismatch");
    $finish;
  end

  // Stimulus
  initial begin
    setting_t s;
    engine_cmd_t c;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = OP_NONE;
    in_corner_ax    = '0;
    in_corner_ay    = '0;
    in_corner_bx    = '0;
    in_corner_by    = '0;
    in_ink          = 1'b0;
    in_pattern_row  = '0;
    in_pattern_bits = '0;
    in_read_address = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_INTERIOR_KIND;
    cfg_data        = '0;
    mismatches      = 0;
    no_idle         = 1'b0;
    hold_go         = 1'b0;
    last_x          = 0;
    last_y          = 0;
    last_w          = 0;
    last_h          = 0;
    for (int i = 0; i < STORE_BYTES; i++) frame_model[i] = 8'h00;
    for (int i = 0; i < 16; i++) user_rows[i] = 16'h0000;
    regs = '{interior_kind: KIND_SOLID, style_index: 4'd1, write_mode: MODE_REPLACE,
             clip_left: 10'd0, clip_top: 9'd0, clip_right: 10'd639, clip_bottom: 9'd399};

    // Hold reset, then release it
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table under reset settings
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_cmd(directed[i]);
    end
    drain(IDLE_PAUSE);

    // Random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < NUM_FIXED) begin
        s = plan[p];
      end else begin
        s.kind  = 3'($urandom_range(0, 7));
        s.style = 4'($urandom_range(0, 15));
        s.mode  = 3'($urandom_range(0, 7));
        s.cl    = 10'($urandom_range(0, 639));
        s.cr    = 10'(s.cl + $urandom_range(0, 120));
        s.ct    = 9'($urandom_range(0, 399));
        s.cb    = 9'(s.ct + $urandom_range(0, 60));
        s.tight = 1'b1;
      end
      apply_setting(s);
      no_idle = (p == 1);
      if (p == 3) hold_go = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_cmd(random_cmd(s.tight));
      end
      // close the phase with a readback so the fills are known to be done
      c         = random_cmd(s.tight);
      c.op      = OP_READ;
      c.has_lit = 1'b0;
      send_cmd(c);
      drain(IDLE_PAUSE);
    end

    drain(END_PAUSE);
    if (mismatches == 0 && readback_q.size() == 0) begin
      $display("mono_pattern_rect_fill_core: match");
    end else begin
      $display("mono_pattern_rect_fill_core: mismatch");
    end
    $finish;
  end

endmodule
